// File: hw/rtl/tli_pkg.sv
package tli_pkg;

  // Sample store geometry
  localparam int MAX_SAMPLES = 64;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

  // Field widths
  localparam int DAY_W   = 20;
  localparam int VAL_W   = 32;
  localparam int WIN_W   = 16;
  localparam int ACT_W   = 2;
  localparam int STAT_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Arithmetic widths
  localparam int DIFF_W = VAL_W + 1;          // va - vb
  localparam int PROD_W = DIFF_W + DAY_W + 1; // (va - vb) * (t - db)
  localparam int MAG_W  = PROD_W - 1;         // magnitude of the product
  localparam int SUM_W  = MAG_W + 2;          // vb +/- quotient
  localparam int LO_W   = DAY_W + 2;          // signed lower window edge
  localparam int HI_W   = DAY_W + 1;          // upper window edge
  localparam int DIV_CNT_W = $clog2(MAG_W);

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(16);

  // Action codes
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_EXACT  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_INTERP = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NONE   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_BEFORE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_AFTER  = 2'd1;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic [DAY_W-1:0]        sample_day;
    logic signed [VAL_W-1:0] sample_value;
    logic                    sample_valid;
    logic [DAY_W-1:0]        target_day;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [STAT_W-1:0]       status;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;
    logic append;
    logic start_query;
    logic issue;
    logic decide;
    logic mul;
    logic div_init;
    logic div_step;
    logic add;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic             scan_end;
    logic             have_exact;
    logic             have_before;
    logic             have_after;
    logic [CNT_W-1:0] sample_count;
  } sts_t;

endpackage

// File: hw/rtl/tli_ctrl.sv
module tli_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [tli_pkg::ACT_W-1:0] in_action,
  input  logic                    out_stall,
  input  tli_pkg::sts_t           sts,
  output logic                    in_stall,
  output logic                    out_valid,
  output tli_pkg::cmd_t           cmd
);
  import tli_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_SCAN    = 8'b0000_0010,
    S_DECIDE  = 8'b0000_0100,
    S_MUL     = 8'b0000_1000,
    S_DIVINIT = 8'b0001_0000,
    S_DIV     = 8'b0010_0000,
    S_ADD     = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 accept;
  logic                 out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_action)
            ACT_CLEAR:  cmd.clear = 1'b1;
            ACT_APPEND: cmd.append = 1'b1;
            ACT_QUERY: begin
              cmd.start_query = 1'b1;
              state_nxt       = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // reads stop at the fill count; the last read word is evaluated before moving to S_DECIDE
        if (!sts.scan_end) begin
          cmd.issue = 1'b1;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (!sts.have_exact && sts.have_before && sts.have_after) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIVINIT;
      end
      S_DIVINIT: begin
        cmd.div_init = 1'b1;
        div_cnt_nxt  = DIV_CNT_W'(MAG_W - 1);
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r - 1'b1;
        if (div_cnt_r == '0) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hw/rtl/tli_dp.sv
module tli_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tli_pkg::in_t                    in_data,
  input  logic                            cfg_valid,
  input  logic [tli_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tli_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  tli_pkg::cmd_t                   cmd,
  output tli_pkg::out_t                   out_data,
  output tli_pkg::sts_t                   sts
);
  import tli_pkg::*;

  localparam int ENTRY_W = DAY_W + VAL_W + 1;
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(-64'sd2147483648);

  // Sample memory: {day, value, valid}
  logic [ENTRY_W-1:0] mem [MAX_SAMPLES];
  logic [ENTRY_W-1:0] rd_data_r;
  logic               rd_vld_r;

  logic [WIN_W-1:0] win_before_r, win_after_r;
  logic [CNT_W-1:0] count_r, scan_idx_r;
  logic             full;

  // Query context
  logic [DAY_W-1:0]        t_r;
  logic signed [LO_W-1:0]  lo_r;
  logic [HI_W-1:0]         hi_r;
  logic                    have_exact_r, have_before_r, have_after_r;
  logic signed [VAL_W-1:0] ex_val_r, bv_r, av_r;
  logic [DAY_W-1:0]        bd_r, ad_r;

  // Arithmetic
  logic signed [DIFF_W-1:0] diff_r;
  logic [DAY_W-1:0]         dt_r, den_r;
  logic signed [PROD_W-1:0] prod_r, mag;
  logic [MAG_W-1:0]         quo_r;
  logic [DAY_W-1:0]         rem_r;
  logic                     neg_r;
  logic [DAY_W:0]           trial;
  logic                     ge;
  logic signed [SUM_W-1:0]  q_s, sum;

  logic signed [VAL_W-1:0] res_val_r;
  logic [STAT_W-1:0]       res_stat_r;
  out_t                    out_r;

  // Read word fields
  logic [DAY_W-1:0]        rd_day;
  logic signed [VAL_W-1:0] rd_val;
  logic                    rd_ok;
  logic                    hit_exact, hit_before, hit_after;

  assign full = (count_r == CNT_W'(MAX_SAMPLES));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_before_r <= WINDOW_RESET;
      win_after_r  <= WINDOW_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WIN_BEFORE: win_before_r <= cfg_data;
        CFG_WIN_AFTER:  win_after_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Fill count and scan pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      scan_idx_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      if (cmd.clear) begin
        count_r <= '0;
      end else if (cmd.append && !full) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.start_query) begin
        scan_idx_r <= '0;
      end else if (cmd.issue) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
      rd_vld_r <= cmd.issue;
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.append && !full) begin
      mem[count_r[ADDR_W-1:0]] <= {in_data.sample_day, in_data.sample_value,
                                   in_data.sample_valid};
    end
    if (cmd.issue) begin
      rd_data_r <= mem[scan_idx_r[ADDR_W-1:0]];
    end
  end

  // Window tests on the word just read
  always_comb begin
    rd_day     = rd_data_r[ENTRY_W-1 -: DAY_W];
    rd_val     = rd_data_r[VAL_W:1];
    rd_ok      = rd_vld_r && rd_data_r[0];
    hit_exact  = rd_ok && (rd_day == t_r);
    hit_before = rd_ok && ($signed({2'b00, rd_day}) >= lo_r) && (rd_day < t_r);
    hit_after  = rd_ok && !have_after_r && (rd_day > t_r)
                 && ({1'b0, rd_day} < hi_r);
  end

  // Search results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_exact_r  <= 1'b0;
      have_before_r <= 1'b0;
      have_after_r  <= 1'b0;
    end else if (cmd.start_query) begin
      have_exact_r  <= 1'b0;
      have_before_r <= 1'b0;
      have_after_r  <= 1'b0;
    end else begin
      if (hit_exact)  have_exact_r  <= 1'b1;
      if (hit_before) have_before_r <= 1'b1;
      if (hit_after)  have_after_r  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      t_r  <= in_data.target_day;
      lo_r <= $signed({2'b00, in_data.target_day}) - $signed({6'b0, win_before_r});
      hi_r <= {1'b0, in_data.target_day} + HI_W'(win_after_r);
    end
    if (hit_exact) begin
      ex_val_r <= rd_val;
    end
    if (hit_before) begin
      bd_r <= rd_day;
      bv_r <= rd_val;
    end
    if (hit_after) begin
      ad_r <= rd_day;
      av_r <= rd_val;
    end
  end

  // Divider step: one quotient bit per cycle; also the product magnitude and the final sum
  always_comb begin
    mag   = prod_r[PROD_W-1] ? -prod_r : prod_r;
    trial = {rem_r, quo_r[MAG_W-1]};
    ge    = (trial >= {1'b0, den_r});
    q_s   = $signed(SUM_W'(quo_r));
    sum   = neg_r ? SUM_W'(bv_r) - q_s : SUM_W'(bv_r) + q_s;
  end

  // Arithmetic pipeline and result register
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      diff_r <= DIFF_W'(av_r) - DIFF_W'(bv_r);
      dt_r   <= t_r - bd_r;
      den_r  <= ad_r - bd_r;
      if (have_exact_r) begin
        res_val_r  <= ex_val_r;
        res_stat_r <= STAT_EXACT;
      end else if (have_before_r && have_after_r) begin
        res_stat_r <= STAT_INTERP;
      end else begin
        res_val_r  <= '0;
        res_stat_r <= STAT_NONE;
      end
    end
    if (cmd.mul) begin
      prod_r <= diff_r * $signed({1'b0, dt_r});
    end
    if (cmd.div_init) begin
      quo_r <= mag[MAG_W-1:0];
      neg_r <= prod_r[PROD_W-1];
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      quo_r <= {quo_r[MAG_W-2:0], ge};
      rem_r <= ge ? DAY_W'(trial - {1'b0, den_r}) : trial[DAY_W-1:0];
    end
    if (cmd.add) begin
      if (sum > SUM_MAX) begin
        res_val_r <= SUM_MAX[VAL_W-1:0];
      end else if (sum < SUM_MIN) begin
        res_val_r <= SUM_MIN[VAL_W-1:0];
      end else begin
        res_val_r <= sum[VAL_W-1:0];
      end
    end
    if (cmd.load_out) begin
      out_r.value  <= res_val_r;
      out_r.status <= res_stat_r;
    end
  end

  assign out_data = out_r;

  assign sts.scan_end     = (scan_idx_r == count_r);
  assign sts.have_exact   = have_exact_r;
  assign sts.have_before  = have_before_r;
  assign sts.have_after   = have_after_r;
  assign sts.sample_count = count_r;

endmodule

// File: hw/rtl/time_window_linear_interpolator_core.sv
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   in_t  (action, sample, target day)
// out_     output     out_valid/out_stall out_t (value, status)
// cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data (window sizes)
//
// Clear and append transactions are handled without leaving the idle state.
// A query scans the store, reading one sample a cycle from the single-port
// store, and then answers directly for an exact match or no value; when
// interpolating, a multiply, a restoring divider that produces one quotient bit
// per cycle of its 53-bit quotient, and an add come before the answer.
// Synchronous active-low reset clears the fill count, windows go to 16 days.
// The output register frees the input side while a result waits on out_stall.
module time_window_linear_interpolator_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tli_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output tli_pkg::out_t                   out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tli_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tli_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tli_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  tli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .out_stall (out_stall),
    .sts       (sts),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  tli_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .out_data  (out_data),
    .sts       (sts)
  );

  // A missing value is reported as zero
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STAT_NONE) |-> (out_data.value == '0))
    else $error("status none with non-zero value");

  // Fill count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sts.sample_count <= CNT_W'(MAX_SAMPLES))
    else $error("sample count beyond store depth");

  // An accepted query keeps the input side busy in the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.action == ACT_QUERY) |=> in_stall)
    else $error("query accepted without busy period");

  // A new result follows a busy cycle of the sequencer
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a query in progress");

endmodule

// File: sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tli_pkg::*;

  localparam int RUN_LIMIT    = 1_000_000;
  localparam int HOLD_CYCLES  = 800;
  localparam int DRAIN_CYCLES = MAX_SAMPLES + 70;
  localparam int IDLE_PCT     = 33;
  localparam int N_PHASES     = 12;
  localparam int PHASE_ITEMS  = 108;
  localparam int MAX_REPORTS  = 10;
  localparam logic [DAY_W-1:0] DAY_TOP = '1;

  // Action code with no meaning to the block
  localparam logic [ACT_W-1:0] ACT_UNKNOWN = 2'd3;

  // Clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // DUT connections
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  time_window_linear_interpolator_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of the series store and the window registers
  logic [DAY_W-1:0]        day_mem [MAX_SAMPLES];
  logic signed [VAL_W-1:0] val_mem [MAX_SAMPLES];
  logic                    vld_mem [MAX_SAMPLES];
  int                      fill_level = 0;
  logic [WIN_W-1:0]        win_before = WINDOW_RESET;
  logic [WIN_W-1:0]        win_after  = WINDOW_RESET;

  in_t  in_pending[$];
  out_t due_answers[$];

  bit steady   = 1'b0;
  int hold_req = 0;

  int n_items    = 0;
  int n_cfg      = 0;
  int n_mismatch = 0;
  int n_exact    = 0;
  int n_interp   = 0;
  int n_none     = 0;
  int n_cycles   = 0;

  // Answer to a query on the shadow series
  function automatic out_t gap_fill_answer(logic [DAY_W-1:0] tday);
    longint t, lo, hi, d, db, da, vb, va, num, den, r;
    bit     hx, hb, ha;
    int     ex, bi, ai;
    out_t   res;
    t  = tday;
    lo = t - longint'(win_before);
    hi = t + longint'(win_after);
    hx = 0; hb = 0; ha = 0;
    ex = 0; bi = 0; ai = 0;
    for (int i = 0; i < fill_level; i++) begin
      d = day_mem[i];
      if (vld_mem[i]) begin
        if (d == t) begin
          hx = 1; ex = i;
        end
        if (d >= lo && d < t) begin
          hb = 1; bi = i;
        end
        if (!ha && d > t && d < hi) begin
          ha = 1; ai = i;
        end
      end
    end
    if (hx) begin
      res.value  = val_mem[ex];
      res.status = STAT_EXACT;
    end else if (hb && ha) begin
      db  = day_mem[bi];
      da  = day_mem[ai];
      vb  = val_mem[bi];
      va  = val_mem[ai];
      num = (va - vb) * (t - db);
      den = da - db;
      r   = vb + num / den;
      if (r > 64'sd2147483647)  r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      res.value  = VAL_W'(r);
      res.status = STAT_INTERP;
    end else begin
      res.value  = '0;
      res.status = STAT_NONE;
    end
    return res;
  endfunction

  // Update the shadow with one accepted transaction
  task automatic track_item(in_t it);
    case (it.action)
      ACT_CLEAR: fill_level = 0;
      ACT_APPEND: begin
        if (fill_level < MAX_SAMPLES) begin
          day_mem[fill_level] = it.sample_day;
          val_mem[fill_level] = it.sample_value;
          vld_mem[fill_level] = it.sample_valid;
          fill_level++;
        end
      end
      ACT_QUERY: due_answers.push_back(gap_fill_answer(it.target_day));
      default: ;
    endcase
  endtask

  // Sender: present queued transactions, hold them while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_item(in_data);
        void'(in_pending.pop_front());
      end
      if (!(in_valid && in_stall)) begin
        if (in_pending.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_data  <= in_pending[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off of the receiver, counted in cycles
  int hold_seen = 0;
  int hold_left = 0;
  bit hold_on   = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left = 0;
      hold_on  <= 1'b0;
    end else begin
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      hold_on <= (hold_left > 0);
    end
  end

  // Receiver: check results, random stall plus the long hold-off
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        case (out_data.status)
          STAT_EXACT:  n_exact++;
          STAT_INTERP: n_interp++;
          default:     n_none++;
        endcase
        if (due_answers.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= MAX_REPORTS)
            $display("%0t: unexpected result value %0d status %0d", $realtime,
                     out_data.value, out_data.status);
        end else begin
          want = due_answers.pop_front();
          if (want.value !== out_data.value || want.status !== out_data.status) begin
            n_mismatch++;
            if (n_mismatch <= MAX_REPORTS)
              $display("%0t: mismatch exp value %0d status %0d, got value %0d status %0d",
                       $realtime, want.value, want.status, out_data.value,
                       out_data.status);
          end
        end
      end
      out_stall <= hold_on || (!steady && ($urandom_range(99) < IDLE_PCT));
    end
  end

  // Watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles >= RUN_LIMIT) begin
      $display("Timeout after %0d cycles", n_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic in_t make_item(logic [ACT_W-1:0] act, longint day,
                                    logic [VAL_W-1:0] val, logic vld, longint tday);
    in_t it;
    it.action       = act;
    it.sample_day   = DAY_W'(day);
    it.sample_value = val;
    it.sample_valid = vld;
    it.target_day   = DAY_W'(tday);
    return it;
  endfunction

  function automatic longint clamp_day(longint d);
    if (d < 0) return 0;
    if (d > longint'(DAY_TOP)) return longint'(DAY_TOP);
    return d;
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    if ($urandom_range(9) < 3) return VAL_W'($urandom_range(2000)) - VAL_W'(1000);
    return $urandom;
  endfunction

  task automatic offer(in_t it);
    in_pending.push_back(it);
    if (it.action != ACT_UNKNOWN) n_items++;
  endtask

  // One dated series with queries around it, or a noise transaction
  task automatic add_series();
    int     k, nq, span;
    longint base;
    in_t    it;
    if ($urandom_range(99) < 15) begin
      it.action       = ACT_W'($urandom_range(3));
      it.sample_day   = DAY_W'($urandom);
      it.sample_value = $urandom;
      it.sample_valid = 1'($urandom_range(1));
      it.target_day   = DAY_W'($urandom);
      offer(it);
    end else begin
      if ($urandom_range(9) != 0) offer(make_item(ACT_CLEAR, 0, '0, 1'b0, 0));
      case ($urandom_range(4))
        0:       base = $urandom_range(40);
        1:       base = longint'(DAY_TOP) - $urandom_range(300);
        default: base = $urandom_range(longint'(DAY_TOP));
      endcase
      k    = ($urandom_range(9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 12);
      span = $urandom_range(1, 64);
      for (int i = 0; i < k; i++) begin
        offer(make_item(ACT_APPEND, clamp_day(base + $urandom_range(span)), rand_value(),
                        $urandom_range(9) != 0, $urandom));
        if ($urandom_range(7) == 0)
          offer(make_item(ACT_QUERY, $urandom, $urandom, 1'($urandom_range(1)),
                          clamp_day(base + $urandom_range(span))));
      end
      nq = $urandom_range(1, 6);
      for (int i = 0; i < nq; i++)
        offer(make_item(ACT_QUERY, $urandom, $urandom, 1'($urandom_range(1)),
                        clamp_day(base - 4 + $urandom_range(span + 8))));
    end
  endtask

  // Window write; only issued while the block is idle
  task automatic write_window(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_WIN_BEFORE) win_before = val;
    else win_after = val;
    n_cfg++;
  endtask

  task automatic settle();
    while (in_pending.size() != 0 || in_valid || due_answers.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Stimulus sequence
  initial begin
    int goal;
    logic [WIN_W-1:0] wb, wa;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under the reset windows
    offer(make_item(ACT_CLEAR, 0, '0, 1'b0, 0));
    offer(make_item(ACT_QUERY, 0, '0, 1'b0, 0));                 // empty series
    offer(make_item(ACT_UNKNOWN, DAY_TOP, '1, 1'b1, DAY_TOP));   // ignored
    offer(make_item(ACT_APPEND, 0, 32'h0001_0000, 1'b1, 0));
    offer(make_item(ACT_APPEND, 10, 32'h0005_0000, 1'b1, 0));
    offer(make_item(ACT_QUERY, 0, '0, 1'b0, 3));                 // window below day 0
    offer(make_item(ACT_QUERY, 0, '0, 1'b0, 0));                 // exact
    offer(make_item(ACT_APPEND, 5, 32'd123, 1'b0, 0));           // missing value
    offer(make_item(ACT_QUERY, 0, '0, 1'b0, 5));
    offer(make_item(ACT_APPEND, 5, -32'sd7, 1'b1, 0));
    offer(make_item(ACT_APPEND, 5, 32'd9, 1'b1, 0));
    offer(make_item(ACT_QUERY, 0, '0, 1'b0, 5));                 // last exact wins
    offer(make_item(ACT_APPEND, DAY_TOP - 15, 32'h7FFF_FFFF, 1'b1, 0));
    offer(make_item(ACT_APPEND, DAY_TOP, 32'h8000_0000, 1'b1, 0));
    offer(make_item(ACT_QUERY, 0, '0, 1'b0, DAY_TOP - 7));       // full-scale swing
    offer(make_item(ACT_QUERY, 0, '0, 1'b0, DAY_TOP));
    offer(make_item(ACT_QUERY, 0, '0, 1'b0, DAY_TOP - 1));
    offer(make_item(ACT_CLEAR, 0, '0, 1'b0, 0));
    offer(make_item(ACT_QUERY, 0, '0, 1'b0, 5));                 // cleared
    offer(make_item(ACT_APPEND, 20, 32'h8000_0000, 1'b1, 0));
    offer(make_item(ACT_APPEND, 40, 32'h7FFF_FFFF, 1'b1, 0));
    offer(make_item(ACT_QUERY, 0, '0, 1'b0, 30));
    offer(make_item(ACT_QUERY, 0, '0, 1'b0, 25));
    offer(make_item(ACT_QUERY, 0, '0, 1'b0, 36));                // before at the lower window edge
    settle();

    // Random phases, each under its own window setting
    goal = n_items;
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin wb = '0;  wa = '0;  end
        1: begin wb = '1;  wa = '1;  end
        2: begin wb = WIN_W'(16); wa = WIN_W'(16); end
        3: begin wb = WIN_W'(0);  wa = WIN_W'(1);  end
        4: begin wb = WIN_W'(1);  wa = WIN_W'(0);  end
        default: begin
          wb = ($urandom_range(3) == 0) ? WIN_W'($urandom) : WIN_W'($urandom_range(48));
          wa = ($urandom_range(3) == 0) ? WIN_W'($urandom) : WIN_W'($urandom_range(48));
        end
      endcase
      write_window(CFG_WIN_BEFORE, wb);
      write_window(CFG_WIN_AFTER, wa);
      @(negedge clk);
      // phase 2 runs without idling and with the receiver held off
      steady = (p == 2);
      if (p == 2) hold_req++;
      goal += PHASE_ITEMS;
      while (n_items < goal) add_series();
      settle();
      @(negedge clk);
      steady = 1'b0;
    end

    $display("Covered %0d transactions and %0d window writes over %0d phases", n_items,
             n_cfg, N_PHASES + 1);
    $display("Answers: %0d exact, %0d interpolated, %0d without value", n_exact,
             n_interp, n_none);
    if (n_mismatch == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
